### rtl/core/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define BFP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under reset.
`define BFP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/bfp_pkg.sv
// Shared types and constants of the frame table parser.
package bfp_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int ENTRY_BYTES     = 24;
    localparam logic [31:0] BLOB_MAGIC = 32'h424C5445;
    localparam int MIN_HEADER      = 8;
    localparam int TABLE_START     = 12;

    // last byte positions of the header words
    localparam int MAGIC_END  = 3;
    localparam int HSIZE_END  = 7;
    localparam int COUNT_END  = 11;

    // last byte positions inside a table entry
    localparam int ENTRY_PK_END = 3;
    localparam int ENTRY_UP_END = 7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int TDATA_W     = 128;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_HSIZE,
        PH_COUNT,
        PH_TABLE,
        PH_DATA,
        PH_SINGLE,
        PH_BAD
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_TOO_SMALL,
        ST_BAD_MAGIC,
        ST_TRUNC_COUNT,
        ST_TRUNC_TABLE,
        ST_PAST_END
    } status_t;

    typedef struct packed {
        logic        record_kind;
        logic [23:0] frame_number;
        logic [31:0] frame_offset;
        logic [31:0] packed_size;
        logic [31:0] unpacked_size;
        status_t     status;
        logic        final_mark;
    } rec_t;

    typedef struct packed {
        logic [1:0] count;
        rec_t       first;
        rec_t       second;
    } push_t;

endpackage

### rtl/core/bfp_parser.sv
// Header and frame table parse state, one byte per request, up to two results.
module bfp_parser #(
    parameter int LENGTH_BITS = bfp_pkg::LENGTH_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output bfp_pkg::push_t  push
);

    localparam int AW = LENGTH_BITS + 1;
    localparam int EW = ((AW > 32) ? AW : 32) + 1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [AW-1:0]          ACC_MAX = '1;
    localparam logic [EW-1:0]          U32_MAX_E = EW'(32'hFFFFFFFF);

    logic [LENGTH_BITS-1:0] byte_cnt_reg, byte_cnt_next, cnt_inc;
    bfp_pkg::phase_t        phase_reg, phase_next, phase_mid;
    logic [31:0]            word_reg, word_next, word_mid;
    logic [23:0]            count_reg, count_next, count_mid;
    logic [23:0]            index_reg, index_next, index_mid, index_inc;
    logic [4:0]             epos_reg, epos_next, epos_mid;
    logic [31:0]            held_reg, held_next, held_mid;
    logic [AW-1:0]          acc_reg, acc_next, acc_mid;

    logic [EW-1:0]          acc_init_e, acc_add_e, acc_reg_e, diff_e;
    logic [AW-1:0]          acc_init, acc_add;
    logic [LENGTH_BITS-1:0] single_diff;
    logic                   frame_hit, single_hit;
    bfp_pkg::status_t       status_code;
    bfp_pkg::rec_t          frame_rec, single_rec, status_rec;

    always_comb
    begin
        word_mid   = {word_reg[23:0], data_byte};
        cnt_inc    = (byte_cnt_reg != LEN_MAX) ? byte_cnt_reg + LENGTH_BITS'(1) : byte_cnt_reg;
        index_inc  = index_reg + 24'd1;
        acc_init_e = EW'(bfp_pkg::TABLE_START) + (EW'(word_mid[23:0]) << 4)
                   + (EW'(word_mid[23:0]) << 3);
        acc_init   = (acc_init_e > EW'(ACC_MAX)) ? ACC_MAX : AW'(acc_init_e);
        acc_add_e  = EW'(acc_reg) + EW'(held_reg);
        acc_add    = (acc_add_e > EW'(ACC_MAX)) ? ACC_MAX : AW'(acc_add_e);
    end

    // next state
    always_comb
    begin
        phase_mid = phase_reg;
        count_mid = count_reg;
        index_mid = index_reg;
        epos_mid  = epos_reg;
        held_mid  = held_reg;
        acc_mid   = acc_reg;
        case (phase_reg)
            bfp_pkg::PH_MAGIC:
            begin
                if (byte_cnt_reg == LENGTH_BITS'(bfp_pkg::MAGIC_END))
                begin
                    phase_mid = (word_mid == bfp_pkg::BLOB_MAGIC) ? bfp_pkg::PH_HSIZE
                                                                  : bfp_pkg::PH_BAD;
                end
            end
            bfp_pkg::PH_HSIZE:
            begin
                if (byte_cnt_reg == LENGTH_BITS'(bfp_pkg::HSIZE_END))
                begin
                    phase_mid = (word_mid == 32'd0) ? bfp_pkg::PH_SINGLE : bfp_pkg::PH_COUNT;
                end
            end
            bfp_pkg::PH_COUNT:
            begin
                if (byte_cnt_reg == LENGTH_BITS'(bfp_pkg::COUNT_END))
                begin
                    count_mid = word_mid[23:0];
                    acc_mid   = acc_init;
                    index_mid = 24'd0;
                    epos_mid  = 5'd0;
                    phase_mid = (word_mid[23:0] != 24'd0) ? bfp_pkg::PH_TABLE
                                                           : bfp_pkg::PH_DATA;
                end
            end
            bfp_pkg::PH_TABLE:
            begin
                if (epos_reg == 5'(bfp_pkg::ENTRY_PK_END))
                begin
                    held_mid = word_mid;
                end
                if (epos_reg == 5'(bfp_pkg::ENTRY_UP_END))
                begin
                    acc_mid = acc_add;
                end
                if (epos_reg >= 5'(bfp_pkg::ENTRY_BYTES - 1))
                begin
                    epos_mid  = 5'd0;
                    index_mid = index_inc;
                    if (index_inc == count_reg)
                    begin
                        phase_mid = bfp_pkg::PH_DATA;
                    end
                end
                else
                begin
                    epos_mid = epos_reg + 5'd1;
                end
            end
            default:
            begin
            end
        endcase

        byte_cnt_next = byte_cnt_reg;
        phase_next    = phase_reg;
        word_next     = word_reg;
        count_next    = count_reg;
        index_next    = index_reg;
        epos_next     = epos_reg;
        held_next     = held_reg;
        acc_next      = acc_reg;
        if (in_fire)
        begin
            if (last_byte)
            begin
                byte_cnt_next = '0;
                phase_next    = bfp_pkg::PH_MAGIC;
                word_next     = '0;
                count_next    = '0;
                index_next    = '0;
                epos_next     = '0;
                held_next     = '0;
                acc_next      = '0;
            end
            else
            begin
                byte_cnt_next = cnt_inc;
                phase_next    = phase_mid;
                word_next     = word_mid;
                count_next    = count_mid;
                index_next    = index_mid;
                epos_next     = epos_mid;
                held_next     = held_mid;
                acc_next      = acc_mid;
            end
        end
    end

    // results
    always_comb
    begin
        acc_reg_e   = EW'(acc_reg);
        single_diff = cnt_inc - LENGTH_BITS'(bfp_pkg::MIN_HEADER);
        diff_e      = EW'(single_diff);

        case (phase_mid)
            bfp_pkg::PH_MAGIC,
            bfp_pkg::PH_HSIZE:
                status_code = bfp_pkg::ST_TOO_SMALL;
            bfp_pkg::PH_BAD:
                status_code = (cnt_inc < LENGTH_BITS'(bfp_pkg::MIN_HEADER))
                            ? bfp_pkg::ST_TOO_SMALL : bfp_pkg::ST_BAD_MAGIC;
            bfp_pkg::PH_COUNT:
                status_code = bfp_pkg::ST_TRUNC_COUNT;
            bfp_pkg::PH_TABLE:
                status_code = bfp_pkg::ST_TRUNC_TABLE;
            bfp_pkg::PH_SINGLE:
                status_code = bfp_pkg::ST_OK;
            default:
                status_code = (EW'(acc_mid) > EW'(cnt_inc)) ? bfp_pkg::ST_PAST_END
                                                           : bfp_pkg::ST_OK;
        endcase

        frame_rec               = '0;
        frame_rec.record_kind   = bfp_pkg::KIND_FRAME;
        frame_rec.frame_number  = index_reg;
        frame_rec.frame_offset  = (acc_reg_e > U32_MAX_E) ? 32'hFFFFFFFF : acc_reg_e[31:0];
        frame_rec.packed_size   = held_reg;
        frame_rec.unpacked_size = word_mid;
        frame_rec.status        = bfp_pkg::ST_OK;

        single_rec              = '0;
        single_rec.record_kind  = bfp_pkg::KIND_FRAME;
        single_rec.frame_offset = 32'(bfp_pkg::MIN_HEADER);
        single_rec.packed_size  = (diff_e > U32_MAX_E) ? 32'hFFFFFFFF : diff_e[31:0];
        single_rec.status       = bfp_pkg::ST_OK;

        status_rec              = '0;
        status_rec.record_kind  = bfp_pkg::KIND_STATUS;
        status_rec.status       = status_code;
        status_rec.final_mark   = 1'b1;

        frame_hit  = (phase_reg == bfp_pkg::PH_TABLE)
                  && (epos_reg == 5'(bfp_pkg::ENTRY_UP_END));
        single_hit = last_byte && (phase_mid == bfp_pkg::PH_SINGLE);

        push        = '0;
        push.second = status_rec;
        if (frame_hit)
        begin
            push.first = frame_rec;
        end
        else if (single_hit)
        begin
            push.first = single_rec;
        end
        else
        begin
            push.first = status_rec;
        end
        if (in_fire)
        begin
            push.count = 2'(frame_hit) + 2'(single_hit) + 2'(last_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            phase_reg    <= bfp_pkg::PH_MAGIC;
            word_reg     <= '0;
            count_reg    <= '0;
            index_reg    <= '0;
            epos_reg     <= '0;
            held_reg     <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            byte_cnt_reg <= byte_cnt_next;
            phase_reg    <= phase_next;
            word_reg     <= word_next;
            count_reg    <= count_next;
            index_reg    <= index_next;
            epos_reg     <= epos_next;
            held_reg     <= held_next;
            acc_reg      <= acc_next;
        end
    end

endmodule

### rtl/core/bfp_res_queue.sv
// Result queue: takes up to two records per cycle, hands out one.
module bfp_res_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  bfp_pkg::push_t push,
    output logic           space_ok,
    input  logic           pop,
    output logic           head_valid,
    output bfp_pkg::rec_t  head
);

    localparam int CW = bfp_pkg::QPTR_W + 1;

    bfp_pkg::rec_t               entry_reg [bfp_pkg::QUEUE_DEPTH];
    logic [bfp_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [bfp_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        do_pop;

    assign head_valid = (cnt_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign space_ok   = (cnt_reg <= CW'(bfp_pkg::QUEUE_DEPTH - 2));
    assign do_pop     = pop && head_valid;
    assign wr_ptr_inc = wr_ptr_reg + bfp_pkg::QPTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + bfp_pkg::QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + bfp_pkg::QPTR_W'(do_pop);
        cnt_next    = cnt_reg + CW'(push.count) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### rtl/core/blte_frame_table_parser_core.sv
// Top level of the container header and frame table parser.
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | tdata: data_byte; tlast: last_byte
//  m_axis   | out | tdata: frame fields and status; tuser: record_kind;
//           |     | tlast: final_mark
//
// One byte per cycle while s_axis_tready is high. The parse state updates on
// the accepting edge; its records enter a four-entry result queue feeding m_axis.
// s_axis_tready is high while the queue has room for two records; with m_axis
// stalled, bytes that raise no record keep flowing until three records wait.
// rst_n clears parse state and the queue asynchronously. After a request with
// tlast set, the state returns to reset and the next byte starts a new blob.
module blte_frame_table_parser_core #(
    parameter int LENGTH_BITS = bfp_pkg::LENGTH_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [23:0] frame_number, [55:24] frame_offset, [87:56] packed_size,
    // [119:88] unpacked_size, [122:120] status, [127:123] zero
    output logic [bfp_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                        m_axis_tuser,   // [0] record_kind
    output logic                        m_axis_tlast
);

    bfp_pkg::push_t push;
    bfp_pkg::rec_t  head;
    logic           in_fire;
    logic           space_ok;
    logic           head_valid;

    assign s_axis_tready = space_ok;
    assign in_fire       = s_axis_tvalid && space_ok;

    bfp_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .push      (push)
    );

    bfp_res_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (space_ok),
        .pop        (m_axis_tready),
        .head_valid (head_valid),
        .head       (head)
    );

    assign m_axis_tvalid = head_valid;
    assign m_axis_tuser  = head.record_kind;
    assign m_axis_tlast  = head.final_mark;
    assign m_axis_tdata  = {5'd0, head.status, head.unpacked_size, head.packed_size,
                            head.frame_offset, head.frame_number};

endmodule

### rtl/core/bfp_port_checker.sv
// Port-level checks of the parser core, bound to the top level.
`include "assert_macros.svh"

module bfp_port_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [7:0]                  s_axis_tdata,
    input logic                        s_axis_tlast,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [bfp_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                        m_axis_tuser,
    input logic                        m_axis_tlast
);

    logic in_seen;

    assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
                  && (s_axis_tlast == s_axis_tlast);

    `BFP_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    `BFP_ASSERT_IMP(a_last_is_status, clk, rst_n, m_axis_tvalid, m_axis_tlast == m_axis_tuser, "final mark not on status record")

    `BFP_ASSERT_IMP(a_status_clean, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[119:0] == 120'd0 && m_axis_tdata[127:123] == 5'd0, "status record carries frame fields")

    `BFP_ASSERT_IMP(a_frame_ok, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[127:120] == 8'd0, "frame record carries a status")

    `BFP_ASSERT_IMP(a_status_range, clk, rst_n, in_seen || m_axis_tvalid, !m_axis_tvalid || m_axis_tdata[122:120] <= 3'd5, "status code out of range")

endmodule

bind blte_frame_table_parser_core bfp_port_checker u_port_checker (.*);
